// ===== rtl/alad_pkg.sv =====
package alad_pkg;

    localparam int DIFF_W  = 33;
    localparam int ADIFF_W = 25;

    localparam logic signed [63:0] SLOPE_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SLOPE_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [DIFF_W-1:0]  dx0;
        logic signed [DIFF_W-1:0]  dy0;
        logic signed [DIFF_W-1:0]  dz0;
        logic signed [DIFF_W-1:0]  dx1;
        logic signed [DIFF_W-1:0]  dy1;
        logic signed [DIFF_W-1:0]  dz1;
        logic signed [ADIFF_W-1:0] da0;
        logic signed [ADIFF_W-1:0] da1;
    } t_req;

    typedef struct packed {
        logic [31:0] slope;
        logic        sat;
    } t_res;

endpackage

// ===== rtl/arc_length_angle_derivative_unit.sv =====
// channel   dir  handshake          word
// input     in   i_valid / o_stall  i_coord_x, i_coord_y, i_coord_z, i_angle,
//                                   i_first_point, i_last_point
// output    out  o_valid / i_stall  o_slope, o_saturated, o_end_of_curve
//
// The first and the second point of a curve do not start the core. An
// interior point runs on one shared 67-bit add/subtract unit: six shift-add
// squarings, two 33-step square roots and two divisions of 25+COORD_FRAC_BITS
// steps; o_stall is high meanwhile.
// Synchronous active-low reset empties the window and the 3-word result queue.
// A new point is taken while up to one result word waits under i_stall.
module arc_length_angle_derivative_unit #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_coord_x,
    input  logic signed [31:0] i_coord_y,
    input  logic signed [31:0] i_coord_z,
    input  logic signed [23:0] i_angle,
    input  logic               i_first_point,
    input  logic               i_last_point,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_slope,
    output logic               o_saturated,
    output logic               o_end_of_curve
);

    typedef struct packed {
        logic [31:0] slope;
        logic        sat;
        logic        eoc;
    } t_word;

    logic signed [31:0] r_prev_x, r_prev_y, r_prev_z;
    logic signed [31:0] r_older_x, r_older_y, r_older_z;
    logic signed [23:0] r_prev_a, r_older_a;
    logic [1:0]         r_ps;
    logic               r_busy;
    logic               r_last;
    t_word              r_q [0:2];
    logic [1:0]         r_cnt;

    t_word              n_q [0:2];
    logic [1:0]         n_cnt;
    logic [1:0]         c1;
    logic               accept, pop, start, restart;
    logic               push0, push1;
    t_word              w0, w1;
    alad_pkg::t_req     req;
    logic               core_done;
    alad_pkg::t_res     core_res;

    function automatic logic signed [32:0] diff(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        diff = 33'(a) - 33'(b);
    endfunction

    assign o_stall = r_busy | r_cnt[1];
    assign accept  = i_valid & ~o_stall;
    assign o_valid = r_cnt != 2'd0;
    assign pop     = o_valid & ~i_stall;
    assign restart = i_first_point | (r_ps == 2'd0);
    assign start   = accept & ~restart & r_ps[1];

    assign req.dx0 = diff(i_coord_x, r_prev_x);
    assign req.dy0 = diff(i_coord_y, r_prev_y);
    assign req.dz0 = diff(i_coord_z, r_prev_z);
    assign req.dx1 = diff(r_prev_x, r_older_x);
    assign req.dy1 = diff(r_prev_y, r_older_y);
    assign req.dz1 = diff(r_prev_z, r_older_z);
    assign req.da0 = 25'(i_angle) - 25'(r_prev_a);
    assign req.da1 = 25'(r_prev_a) - 25'(r_older_a);

    alad_core #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (req),
        .o_done  (core_done),
        .o_res   (core_res)
    );

    always_comb begin
        push0 = 1'b0;
        push1 = 1'b0;
        w0    = '{slope: '0, sat: 1'b0, eoc: i_last_point};
        w1    = '{slope: '0, sat: 1'b0, eoc: 1'b1};
        if (core_done) begin
            push0 = 1'b1;
            push1 = r_last;
            w0    = '{slope: core_res.slope, sat: core_res.sat, eoc: 1'b0};
        end else if (accept) begin
            if (restart) push0 = 1'b1;
            else if (!r_ps[1]) push0 = i_last_point;
        end
    end

    always_comb begin
        n_q = r_q;
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
        end
        c1 = r_cnt - 2'(pop);
        if (push0) n_q[c1] = w0;
        if (push1) n_q[c1 + 2'd1] = w1;
        n_cnt = c1 + 2'(push0) + 2'(push1);
    end

    assign o_slope        = r_q[0].slope;
    assign o_saturated    = r_q[0].sat;
    assign o_end_of_curve = r_q[0].eoc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps      <= 2'd0;
            r_busy    <= 1'b0;
            r_cnt     <= 2'd0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_prev_z  <= '0;
            r_prev_a  <= '0;
            r_older_x <= '0;
            r_older_y <= '0;
            r_older_z <= '0;
            r_older_a <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_q   <= n_q;
            if (core_done) r_busy <= 1'b0;
            if (accept) begin
                r_prev_x <= i_coord_x;
                r_prev_y <= i_coord_y;
                r_prev_z <= i_coord_z;
                r_prev_a <= i_angle;
                if (restart) begin
                    r_ps <= i_last_point ? 2'd0 : 2'd1;
                end else begin
                    r_older_x <= r_prev_x;
                    r_older_y <= r_prev_y;
                    r_older_z <= r_prev_z;
                    r_older_a <= r_prev_a;
                    r_ps      <= i_last_point ? 2'd0 : 2'd2;
                    if (r_ps[1]) begin
                        r_busy <= 1'b1;
                        r_last <= i_last_point;
                    end
                end
            end
        end
    end

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> o_stall)
        else $error("point taken during computation");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_done |-> r_busy)
        else $error("result without a pending point");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturated) |->
            (o_slope == 32'sh7fffffff || o_slope == 32'sh80000000))
        else $error("saturated word not at a limit");

endmodule

// ===== rtl/alad_core.sv =====
module alad_core #(
    parameter int COORD_FRAC_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  alad_pkg::t_req  i_req,
    output logic            o_done,
    output alad_pkg::t_res  o_res
);

    localparam int NUM_W = alad_pkg::ADIFF_W + COORD_FRAC_BITS;
    localparam int V_W   = NUM_W + 2;
    localparam int CNT_W = $clog2((NUM_W > 33) ? NUM_W : 33);
    localparam int ALU_W = 67;
    localparam int SQ_W  = 66;
    localparam int M_W   = alad_pkg::DIFF_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_RT, S_CHK, S_DV, S_SUM, S_HALF, S_SAT
    } t_state;

    function automatic logic [M_W-1:0] mag_d(input logic signed [M_W-1:0] d);
        mag_d = d[M_W-1] ? M_W'(-d) : M_W'(d);
    endfunction

    function automatic logic [alad_pkg::ADIFF_W-1:0] mag_a(
        input logic signed [alad_pkg::ADIFF_W-1:0] d);
        mag_a = d[alad_pkg::ADIFF_W-1] ? alad_pkg::ADIFF_W'(-d) : alad_pkg::ADIFF_W'(d);
    endfunction

    function automatic logic signed [V_W-1:0] sgn_q(input logic [NUM_W-1:0] q,
                                                   input logic neg);
        logic signed [V_W-1:0] v;
        v = $signed(V_W'(q));
        sgn_q = neg ? -v : v;
    endfunction

    t_state                r_state;
    alad_pkg::t_req        r_req;
    logic                  r_seg;
    logic [1:0]            r_k;
    logic [SQ_W-1:0]       r_acc;
    logic [SQ_W-1:0]       r_mcand;
    logic [M_W-1:0]        r_mplier;
    logic [SQ_W-1:0]       r_sqv;
    logic [36:0]           r_rem;
    logic [M_W-1:0]        r_root;
    logic [CNT_W-1:0]      r_cnt;
    logic [M_W-1:0]        r_len0;
    logic [M_W-1:0]        r_len1;
    logic [NUM_W-1:0]      r_dq;
    logic [34:0]           r_dr;
    logic [NUM_W-1:0]      r_q0;
    logic signed [V_W-1:0] r_val;

    logic [ALU_W-1:0]      alu_a;
    logic [ALU_W-1:0]      alu_b;
    logic                  alu_sub;
    logic [ALU_W:0]        alu_y;
    logic [36:0]           rt_shift;
    logic [34:0]           dv_shift;
    logic [M_W-1:0]        cur_len;
    logic [M_W-1:0]        nxt_mag;
    logic [M_W-1:0]        n_root;
    logic [NUM_W-1:0]      n_dq;
    logic                  qbit;
    logic signed [V_W-1:0] v_adj;
    logic signed [63:0]    v64;

    assign rt_shift = {r_rem[34:0], r_sqv[SQ_W-1 -: 2]};
    assign dv_shift = {r_dr[33:0], r_dq[NUM_W-1]};
    assign cur_len  = r_seg ? r_len1 : r_len0;

    always_comb begin
        case (r_state)
            S_RT: begin
                alu_a   = ALU_W'(rt_shift);
                alu_b   = ALU_W'({r_root, 2'b01});
                alu_sub = 1'b1;
            end
            S_DV: begin
                alu_a   = ALU_W'(dv_shift);
                alu_b   = ALU_W'(cur_len);
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = ALU_W'(r_acc);
                alu_b   = ALU_W'(r_mcand);
                alu_sub = 1'b0;
            end
        endcase
    end

    // borrow in the top bit on subtract
    assign alu_y = {1'b0, alu_a} + ({1'b0, alu_b} ^ {(ALU_W+1){alu_sub}})
                 + (ALU_W+1)'(alu_sub);

    always_comb begin
        case ({r_seg, r_k})
            3'b000:  nxt_mag = mag_d(r_req.dy0);
            3'b001:  nxt_mag = mag_d(r_req.dz0);
            3'b100:  nxt_mag = mag_d(r_req.dy1);
            3'b101:  nxt_mag = mag_d(r_req.dz1);
            default: nxt_mag = '0;
        endcase
    end

    assign n_root = {r_root[M_W-2:0], ~alu_y[ALU_W]};
    assign qbit   = ~alu_y[ALU_W];
    assign n_dq   = {r_dq[NUM_W-2:0], qbit};
    assign v_adj  = r_val + $signed({{(V_W-1){1'b0}}, r_val[V_W-1]});
    assign v64    = 64'(r_val);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= (r_state == S_SAT);
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req    <= i_req;
                        r_seg    <= 1'b0;
                        r_k      <= 2'd0;
                        r_acc    <= '0;
                        r_mcand  <= SQ_W'(mag_d(i_req.dx0));
                        r_mplier <= mag_d(i_req.dx0);
                        r_state  <= S_SQ;
                    end
                end
                S_SQ: begin
                    if (r_mplier == '0) begin
                        if (r_k == 2'd2) begin
                            r_sqv   <= r_acc;
                            r_rem   <= '0;
                            r_root  <= '0;
                            r_cnt   <= '0;
                            r_state <= S_RT;
                        end else begin
                            r_k      <= r_k + 2'd1;
                            r_mcand  <= SQ_W'(nxt_mag);
                            r_mplier <= nxt_mag;
                        end
                    end else begin
                        if (r_mplier[0]) r_acc <= alu_y[SQ_W-1:0];
                        r_mcand  <= r_mcand << 1;
                        r_mplier <= r_mplier >> 1;
                    end
                end
                S_RT: begin
                    r_rem  <= alu_y[ALU_W] ? rt_shift : alu_y[36:0];
                    r_root <= n_root;
                    r_sqv  <= r_sqv << 2;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(32)) begin
                        if (!r_seg) begin
                            r_len0   <= n_root;
                            r_seg    <= 1'b1;
                            r_k      <= 2'd0;
                            r_acc    <= '0;
                            r_mcand  <= SQ_W'(mag_d(r_req.dx1));
                            r_mplier <= mag_d(r_req.dx1);
                            r_state  <= S_SQ;
                        end else begin
                            r_len1  <= n_root;
                            r_state <= S_CHK;
                        end
                    end
                end
                S_CHK: begin
                    if (r_len0 == '0 && r_len1 == '0) begin
                        r_val   <= '0;
                        r_state <= S_SAT;
                    end else if (r_len1 == '0) begin
                        r_val   <= V_W'(r_req.da0);
                        r_state <= S_SAT;
                    end else if (r_len0 == '0) begin
                        r_val   <= V_W'(r_req.da1);
                        r_state <= S_SAT;
                    end else begin
                        r_seg   <= 1'b0;
                        r_dq    <= NUM_W'(mag_a(r_req.da0)) << COORD_FRAC_BITS;
                        r_dr    <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DV;
                    end
                end
                S_DV: begin
                    if (r_cnt == CNT_W'(NUM_W - 1) && !r_seg) begin
                        r_q0  <= n_dq;
                        r_seg <= 1'b1;
                        r_dq  <= NUM_W'(mag_a(r_req.da1)) << COORD_FRAC_BITS;
                        r_dr  <= '0;
                        r_cnt <= '0;
                    end else begin
                        r_dr  <= alu_y[ALU_W] ? dv_shift : alu_y[34:0];
                        r_dq  <= n_dq;
                        r_cnt <= r_cnt + 1'b1;
                        if (r_cnt == CNT_W'(NUM_W - 1)) r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_val   <= sgn_q(r_q0, r_req.da0[alad_pkg::ADIFF_W-1])
                             + sgn_q(r_dq, r_req.da1[alad_pkg::ADIFF_W-1]);
                    r_state <= S_HALF;
                end
                S_HALF: begin
                    r_val   <= v_adj >>> 1;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (v64 > alad_pkg::SLOPE_MAX) begin
                        o_res.slope <= alad_pkg::SLOPE_MAX[31:0];
                        o_res.sat   <= 1'b1;
                    end else if (v64 < alad_pkg::SLOPE_MIN) begin
                        o_res.slope <= alad_pkg::SLOPE_MIN[31:0];
                        o_res.sat   <= 1'b1;
                    end else begin
                        o_res.slope <= v64[31:0];
                        o_res.sat   <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> r_state == S_IDLE)
        else $error("start while core busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> r_state == S_IDLE)
        else $error("done while core busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held for more than one cycle");

endmodule
